>>> hw/rtl/ffba_pkg.sv
package ffba_pkg;

    localparam int MAX_BLOCKS_DEF  = 64;
    localparam int OFFSET_BITS_DEF = 25;

    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 25;
    localparam int ALIGN_W = 4;
    localparam int MARGIN_W = 13;
    localparam int TOTAL_W = 40;
    localparam int PAD_W   = 15;
    localparam int CFG_IDX_W = 2;

    localparam logic [SIZE_W-1:0]   POOL_SIZE_RST = 25'd65536;
    localparam logic [MARGIN_W-1:0] MARGIN_RST    = 13'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POOL_BASE    = 2'd0,
        REG_POOL_SIZE    = 2'd1,
        REG_SPLIT_MARGIN = 2'd2,
        REG_NONE         = 2'd3
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_A_RD,
        S_A_PAD,
        S_A_FIT,
        S_SH_RD,
        S_SH_WR,
        S_A_WR_NEW,
        S_A_WR_CUR,
        S_F_RD,
        S_F_CHK,
        S_F_NRD,
        S_F_NCHK,
        S_F_WRB,
        S_F_PRD,
        S_F_PCHK,
        S_RM_RD,
        S_RM_WR,
        S_RESP
    } state_t;

endpackage

>>> hw/rtl/ffba_if.sv
interface ffba_req_if import ffba_pkg::*;;
    logic               valid;
    logic               ready;
    logic               action;
    logic [SIZE_W-1:0]  request_size;
    logic [ALIGN_W-1:0] align_log2;
    logic [ADDR_W-1:0]  free_address;

    modport source (output valid, action, request_size, align_log2, free_address, input ready);
    modport sink (input valid, action, request_size, align_log2, free_address, output ready);
endinterface

interface ffba_resp_if import ffba_pkg::*;;
    logic               valid;
    logic               ready;
    logic               ok;
    logic [ADDR_W-1:0]  granted_address;
    logic [TOTAL_W-1:0] requested_total;

    modport source (output valid, ok, granted_address, requested_total, input ready);
    modport sink (input valid, ok, granted_address, requested_total, output ready);
endinterface

interface ffba_cfg_if import ffba_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/first_fit_block_allocator_unit.sv
// First-fit block allocator with coalescing.
// Channels: req (allocate or free beat), resp (one result beat per request),
// cfg (register writes: pool_base, pool_size, split_margin; always ready;
// the user must write them only while the unit is idle; the block does not enforce it).
// The block table sits in a synchronous RAM of MAX_BLOCKS entries with a
// registered read port; a request reads and writes it one entry at a time.
// An allocate scans the table in order and shifts entries up when a block is
// split; a free scans, then shifts entries down on each merge. The worst case
// is a free near the head that merges on both sides, since the RAM port and
// the in-order scan set the time taken. One request is in flight at a time.
// Reset (and every pool_size write) passes through an init step that writes
// the single free block that spans the pool; req.ready stays low during it.
// The result sits in an output register; when the receiver stalls, the unit
// finishes the next request's work and then waits to hand its result over.
module first_fit_block_allocator_unit
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    ffba_req_if.sink    req,
    ffba_resp_if.source resp,
    ffba_cfg_if.sink    cfg
);

    localparam int OB = OFFSET_BITS;
    localparam int EW = 2 * OB + 1;
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int NW = ((OB > SIZE_W) ? OB : SIZE_W) + 1;
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);
    localparam logic [32:0] LEN_LIM = (33'(1) << OB) - 33'(1);

    state_t state_reg, state_next;
    logic [CW-1:0] i_reg, i_next, k_reg, k_next, count_reg, count_next;
    logic [OB-1:0] b_off_reg, b_off_next, b_len_reg, b_len_next, need_reg, need_next;
    logic [ADDR_W-1:0] addr_reg, addr_next, rel_reg, rel_next;
    logic [PAD_W-1:0] pad_reg, pad_next;
    logic [SIZE_W-1:0] size_reg, size_next, psize_reg;
    logic [ALIGN_W-1:0] lg_reg, lg_next;
    logic act_reg, act_next, res_ok_reg, res_ok_next, rm_phase_reg, rm_phase_next;
    logic [ADDR_W-1:0] res_addr_reg, res_addr_next, base_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic out_valid_reg, out_valid_next, out_ok_reg, out_ok_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;

    // table RAM
    logic [EW-1:0] mem [MAX_BLOCKS];
    logic [EW-1:0] rd_q, wdata;
    logic [IW-1:0] raddr, waddr;
    logic we;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_q <= mem[raddr];
    end

    logic [OB-1:0] rd_off, rd_len;
    logic rd_used;
    assign rd_off  = rd_q[EW-1:OB+1];
    assign rd_len  = rd_q[OB:1];
    assign rd_used = rd_q[0];

    // initial block length from pool_size
    logic [32:0] init_len;
    always_comb
    begin
        init_len = {8'd0, psize_reg};
        if (init_len == 33'd0)
        begin
            init_len = 33'd1;
        end
        if (init_len > LEN_LIM)
        begin
            init_len = LEN_LIM;
        end
    end

    // alignment helpers
    logic [ADDR_W-1:0] abs_addr, neg_addr;
    logic [PAD_W-1:0] amask;
    logic [NW-1:0] need_w, len_w;
    logic [OB-1:0] rem;
    logic fits, do_split;
    logic [32:0] blk_end;
    logic hit;
    logic [TOTAL_W:0] sum;

    always_comb
    begin
        abs_addr = base_reg + ADDR_W'(rd_off);
        neg_addr = ADDR_W'(0) - abs_addr;
        amask    = PAD_W'((16'(1) << lg_reg) - 16'(1));
        need_w   = NW'(size_reg) + NW'(pad_reg);
        len_w    = NW'(b_len_reg);
        fits     = (len_w >= need_w);
        rem      = OB'(len_w - need_w);
        do_split = (rem != '0) && (NW'(rem) >= NW'(margin_reg)) && (count_reg < CNT_MAX);
        blk_end  = 33'(rd_off) + 33'(rd_len);
        hit      = (33'(rd_off) <= 33'(rel_reg)) && (33'(rel_reg) < blk_end);
        sum      = {1'b0, total_reg} + (TOTAL_W + 1)'(size_reg);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            psize_reg  <= POOL_SIZE_RST;
            margin_reg <= MARGIN_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_POOL_BASE:    base_reg   <= cfg.data;
                REG_POOL_SIZE:    psize_reg  <= cfg.data[SIZE_W-1:0];
                REG_SPLIT_MARGIN: margin_reg <= cfg.data[MARGIN_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign resp.valid = out_valid_reg;
    assign resp.ok = out_ok_reg;
    assign resp.granted_address = out_addr_reg;
    assign resp.requested_total = total_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg;
        k_next = k_reg;
        count_next = count_reg;
        b_off_next = b_off_reg;
        b_len_next = b_len_reg;
        need_next = need_reg;
        addr_next = addr_reg;
        rel_next = rel_reg;
        pad_next = pad_reg;
        size_next = size_reg;
        lg_next = lg_reg;
        act_next = act_reg;
        res_ok_next = res_ok_reg;
        res_addr_next = res_addr_reg;
        rm_phase_next = rm_phase_reg;
        total_next = total_reg;
        out_valid_next = out_valid_reg;
        out_ok_next = out_ok_reg;
        out_addr_next = out_addr_reg;
        we = 1'b0;
        waddr = '0;
        wdata = '0;
        raddr = '0;

        // drop the result once taken
        if (resp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                we = 1'b1;
                wdata = {OB'(0), init_len[OB-1:0], 1'b0};
                count_next = CW'(1);
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next = req.action;
                    size_next = req.request_size;
                    lg_next = req.align_log2;
                    rel_next = req.free_address - base_reg;
                    i_next = '0;
                    res_ok_next = 1'b0;
                    res_addr_next = '0;
                    state_next = req.action ? S_F_RD : S_A_RD;
                end
            end
            S_A_RD:
            begin
                raddr = i_reg[IW-1:0];
                state_next = (i_reg < count_reg) ? S_A_PAD : S_RESP;
            end
            S_A_PAD:
            begin
                if (rd_used)
                begin
                    i_next = i_reg + CW'(1);
                    state_next = S_A_RD;
                end
                else
                begin
                    b_off_next = rd_off;
                    b_len_next = rd_len;
                    addr_next = abs_addr;
                    pad_next = neg_addr[PAD_W-1:0] & amask;
                    state_next = S_A_FIT;
                end
            end
            S_A_FIT:
            begin
                if (!fits)
                begin
                    i_next = i_reg + CW'(1);
                    state_next = S_A_RD;
                end
                else
                begin
                    res_ok_next = 1'b1;
                    res_addr_next = addr_reg + ADDR_W'(pad_reg);
                    need_next = OB'(need_w);
                    if (do_split)
                    begin
                        k_next = count_reg;
                        state_next = S_SH_RD;
                    end
                    else
                    begin
                        we = 1'b1;
                        waddr = i_reg[IW-1:0];
                        wdata = {b_off_reg, b_len_reg, 1'b1};
                        state_next = S_RESP;
                    end
                end
            end
            // shift entries up to open slot i+1
            S_SH_RD:
            begin
                raddr = IW'(k_reg - CW'(1));
                state_next = (k_reg > i_reg + CW'(1)) ? S_SH_WR : S_A_WR_NEW;
            end
            S_SH_WR:
            begin
                we = 1'b1;
                waddr = k_reg[IW-1:0];
                wdata = rd_q;
                k_next = k_reg - CW'(1);
                state_next = S_SH_RD;
            end
            S_A_WR_NEW:
            begin
                we = 1'b1;
                waddr = IW'(i_reg + CW'(1));
                wdata = {b_off_reg + need_reg, b_len_reg - need_reg, 1'b0};
                state_next = S_A_WR_CUR;
            end
            S_A_WR_CUR:
            begin
                we = 1'b1;
                waddr = i_reg[IW-1:0];
                wdata = {b_off_reg, need_reg, 1'b1};
                count_next = count_reg + CW'(1);
                state_next = S_RESP;
            end
            S_F_RD:
            begin
                raddr = i_reg[IW-1:0];
                state_next = (i_reg < count_reg) ? S_F_CHK : S_RESP;
            end
            S_F_CHK:
            begin
                if (hit)
                begin
                    res_ok_next = 1'b1;
                    b_off_next = rd_off;
                    b_len_next = rd_len;
                    state_next = S_F_NRD;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                    state_next = S_F_RD;
                end
            end
            S_F_NRD:
            begin
                raddr = IW'(i_reg + CW'(1));
                state_next = (i_reg + CW'(1) < count_reg) ? S_F_NCHK : S_F_WRB;
            end
            S_F_NCHK:
            begin
                if (!rd_used)
                begin
                    b_len_next = b_len_reg + rd_len;
                    k_next = i_reg + CW'(1);
                    rm_phase_next = 1'b0;
                    state_next = S_RM_RD;
                end
                else
                begin
                    state_next = S_F_WRB;
                end
            end
            S_F_WRB:
            begin
                we = 1'b1;
                waddr = i_reg[IW-1:0];
                wdata = {b_off_reg, b_len_reg, 1'b0};
                state_next = (i_reg != '0) ? S_F_PRD : S_RESP;
            end
            S_F_PRD:
            begin
                raddr = IW'(i_reg - CW'(1));
                state_next = S_F_PCHK;
            end
            S_F_PCHK:
            begin
                if (!rd_used)
                begin
                    we = 1'b1;
                    waddr = IW'(i_reg - CW'(1));
                    wdata = {rd_off, rd_len + b_len_reg, 1'b0};
                    k_next = i_reg;
                    rm_phase_next = 1'b1;
                    state_next = S_RM_RD;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            // close the gap at entry k by shifting entries down
            S_RM_RD:
            begin
                raddr = IW'(k_reg + CW'(1));
                if (k_reg + CW'(1) < count_reg)
                begin
                    state_next = S_RM_WR;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = rm_phase_reg ? S_RESP : S_F_WRB;
                end
            end
            S_RM_WR:
            begin
                we = 1'b1;
                waddr = k_reg[IW-1:0];
                wdata = rd_q;
                k_next = k_reg + CW'(1);
                state_next = S_RM_RD;
            end
            S_RESP:
            begin
                if (!out_valid_reg || resp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next = res_ok_reg;
                    out_addr_next = res_addr_reg;
                    if (!act_reg && res_ok_reg)
                    begin
                        total_next = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase

        // rebuild the table on a pool_size write
        if (cfg.valid && cfg.ready && (cfg.index == REG_POOL_SIZE))
        begin
            state_next = S_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            count_reg     <= CW'(1);
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            k_reg         <= '0;
            rm_phase_reg  <= 1'b0;
            act_reg       <= 1'b0;
            res_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            rm_phase_reg  <= rm_phase_next;
            act_reg       <= act_next;
            res_ok_reg    <= res_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_off_reg    <= b_off_next;
        b_len_reg    <= b_len_next;
        need_reg     <= need_next;
        addr_reg     <= addr_next;
        rel_reg      <= rel_next;
        pad_reg      <= pad_next;
        size_reg     <= size_next;
        lg_reg       <= lg_next;
        res_addr_reg <= res_addr_next;
        out_ok_reg   <= out_ok_next;
        out_addr_reg <= out_addr_next;
    end

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= CNT_MAX))
        else $error("block count out of range");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !we)
        else $error("table write while idle");

    a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESP))
        else $error("result raised outside response step");

endmodule

>>> tb/sv/first_fit_block_allocator_unit_tb.sv
`timescale 1ns / 1ps
module first_fit_block_allocator_unit_tb;
    import ffba_pkg::*;

    localparam int NBLK = 64;
    localparam int OFFB = 25;
    localparam longint TOTAL_LIM = (64'd1 << 40) - 1;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [ADDR_W-1:0]  off;
        logic [ADDR_W-1:0]  len;
        bit                 used;
    } blk_s;

    typedef struct {
        bit                 ok;
        logic [ADDR_W-1:0]  addr;
        logic [TOTAL_W-1:0] total;
    } grant_s;

    logic clk;
    logic rst_n;
    longint cycles;
    int errors;
    bit stall_en;
    bit hold_off;
    int sent_count;
    int got_count;
    int alloc_ok_count;
    int free_ok_count;

    ffba_req_if  req();
    ffba_resp_if resp();
    ffba_cfg_if  cfg();

    first_fit_block_allocator_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .resp  (resp.source),
        .cfg   (cfg.sink)
    );

    // Shadow allocator state
    logic [ADDR_W-1:0]   m_base;
    logic [SIZE_W-1:0]   m_size;
    logic [MARGIN_W-1:0] m_margin;
    blk_s                m_tab[NBLK];
    int                  m_count;
    logic [TOTAL_W-1:0]  m_total;
    grant_s              pending_grants[$];
    logic [ADDR_W-1:0]   live_addrs[$];

    function automatic void rebuild_table();
        longint len;
        len = m_size;
        if (len == 0)
            len = 1;
        if (len > (64'd1 << OFFB) - 1)
            len = (64'd1 << OFFB) - 1;
        for (int i = 0; i < NBLK; i++)
            m_tab[i] = '{0, 0, 0};
        m_tab[0].len = len[ADDR_W-1:0];
        m_count = 1;
    endfunction

    function automatic void drop_entry(int i);
        for (int k = i; k + 1 < m_count; k++)
            m_tab[k] = m_tab[k + 1];
        m_count--;
    endfunction

    function automatic bit fit_block(logic [SIZE_W-1:0] sz, logic [ALIGN_W-1:0] lg,
                                     output logic [ADDR_W-1:0] addr);
        longint amask, pad, need, a;
        amask = (64'd1 << lg) - 1;
        for (int i = 0; i < m_count; i++) begin
            if (m_tab[i].used)
                continue;
            a = (longint'(m_base) + m_tab[i].off) & 64'hFFFF_FFFF;
            pad = (-a) & amask;
            need = longint'(sz) + pad;
            if (m_tab[i].len < need)
                continue;
            if (m_tab[i].len - need >= m_margin && m_tab[i].len > need
                && m_count < NBLK) begin
                for (int k = m_count; k > i + 1; k--)
                    m_tab[k] = m_tab[k - 1];
                m_tab[i + 1].off = ADDR_W'(m_tab[i].off + need);
                m_tab[i + 1].len = ADDR_W'(m_tab[i].len - need);
                m_tab[i + 1].used = 0;
                m_tab[i].len = ADDR_W'(need);
                m_count++;
            end
            m_tab[i].used = 1;
            addr = ADDR_W'((a + pad) & 64'hFFFF_FFFF);
            return 1;
        end
        addr = 0;
        return 0;
    endfunction

    function automatic bit release_block(logic [ADDR_W-1:0] fa);
        logic [ADDR_W-1:0] rel;
        rel = fa - m_base;
        for (int i = 0; i < m_count; i++) begin
            if (m_tab[i].off <= rel && longint'(rel) < longint'(m_tab[i].off) + m_tab[i].len)
            begin
                m_tab[i].used = 0;
                if (i + 1 < m_count && !m_tab[i + 1].used) begin
                    m_tab[i].len += m_tab[i + 1].len;
                    drop_entry(i + 1);
                end
                if (i > 0 && !m_tab[i - 1].used) begin
                    m_tab[i - 1].len += m_tab[i].len;
                    drop_entry(i);
                end
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic grant_s predict_grant(bit act, logic [SIZE_W-1:0] sz,
                                             logic [ALIGN_W-1:0] lg, logic [ADDR_W-1:0] fa);
        grant_s g;
        longint t;
        g.addr = 0;
        if (!act) begin
            g.ok = fit_block(sz, lg, g.addr);
            if (g.ok) begin
                t = longint'(m_total) + sz;
                m_total = (t > TOTAL_LIM) ? TOTAL_LIM[TOTAL_W-1:0] : t[TOTAL_W-1:0];
                live_addrs.push_back(g.addr);
            end
        end else begin
            g.ok = release_block(fa);
        end
        g.total = m_total;
        return g;
    endfunction

    // Clock and watchdog
    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Long receiver hold-off, counted in its own process
    task automatic long_hold(int n);
        hold_off = 1;
        repeat (n) @(posedge clk);
        hold_off = 0;
    endtask

    // Receiver: random stall bursts, check each result beat
    initial begin
        int gap;
        gap = 0;
        resp.ready = 0;
        forever begin
            @(posedge clk);
            if (resp.valid && resp.ready) begin
                got_count++;
                if (pending_grants.size() == 0) begin
                    $error("result beat with no expectation");
                    errors++;
                end else begin
                    grant_s e;
                    e = pending_grants.pop_front();
                    if (resp.ok !== e.ok) begin
                        $error("ok: expected %0d actual %0d", e.ok, resp.ok);
                        errors++;
                    end
                    if (resp.granted_address !== e.addr) begin
                        $error("granted_address: expected %h actual %h",
                               e.addr, resp.granted_address);
                        errors++;
                    end
                    if (resp.requested_total !== e.total) begin
                        $error("requested_total: expected %h actual %h",
                               e.total, resp.requested_total);
                        errors++;
                    end
                end
            end
            if (gap > 0)
                gap--;
            else if (stall_en && $urandom_range(0, 7) == 0)
                gap = $urandom_range(1, 15);
            resp.ready <= !hold_off && gap == 0;
        end
    end

    // Send one request beat, with optional random gap before it; valid stays
    // high after acceptance until the next random gap or drain() lowers it
    task automatic send_request(bit act, logic [SIZE_W-1:0] sz, logic [ALIGN_W-1:0] lg,
                                logic [ADDR_W-1:0] fa);
        if (stall_en && $urandom_range(0, 7) == 0) begin
            req.valid <= 0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        req.valid <= 1;
        req.action <= act;
        req.request_size <= sz;
        req.align_log2 <= lg;
        req.free_address <= fa;
        do
            @(posedge clk);
        while (!req.ready);
        pending_grants.push_back(predict_grant(act, sz, lg, fa));
        sent_count++;
    endtask

    task automatic drain();
        req.valid <= 0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [ADDR_W-1:0] val);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data <= val;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 0;
        case (idx)
            REG_POOL_BASE: m_base = val;
            REG_POOL_SIZE:
            begin
                m_size = val[SIZE_W-1:0];
                rebuild_table();
                live_addrs.delete();
            end
            REG_SPLIT_MARGIN: m_margin = val[MARGIN_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic setup_pool(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] sz,
                              logic [ADDR_W-1:0] margin);
        drain();
        write_reg(REG_POOL_BASE, base);
        write_reg(REG_POOL_SIZE, sz);
        write_reg(REG_SPLIT_MARGIN, margin);
    endtask

    // Pick a free address: mostly a granted one, sometimes anywhere
    function automatic logic [ADDR_W-1:0] pick_free_addr();
        int k;
        if (live_addrs.size() != 0 && $urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, live_addrs.size() - 1);
            pick_free_addr = live_addrs[k] + $urandom_range(0, 3);
            live_addrs.delete(k);
        end else begin
            pick_free_addr = $urandom;
        end
    endfunction

    task automatic test_directed();
        setup_pool(32'h0, 32'd65536, 32'd64);
        send_request(0, 25'd100, 4'd0, 32'h0);
        send_request(0, 25'd0, 4'd12, 32'h0);
        send_request(0, 25'h1FF_FFFF, 4'd15, 32'hFFFF_FFFF);
        send_request(0, 25'd10, 4'd15, 32'h0);
        send_request(1, 25'h1FF_FFFF, 4'hF, 32'h0);
        send_request(1, 25'd0, 4'd0, 32'h50);
        send_request(1, 25'd0, 4'd0, 32'hFFFF_FFFF);
        send_request(1, 25'd0, 4'd0, 32'h0001_0000);
        // wrapping base, zero margin, tiny pool
        setup_pool(32'hFFFF_FFF0, 32'd0, 32'd0);
        send_request(0, 25'd1, 4'd0, 32'h0);
        send_request(0, 25'd1, 4'd0, 32'h0);
        send_request(1, 25'd0, 4'd0, 32'hFFFF_FFF0);
        setup_pool(32'hFFFF_FF00, 32'd4096, 32'd4096);
        send_request(0, 25'd16, 4'd8, 32'h0);
        send_request(0, 25'd16, 4'd3, 32'h0);
        send_request(1, 25'd0, 4'd0, 32'h0);
        // largest pool size that still fits the block length field
        setup_pool(32'hAAAA_5555, 32'h01FF_FFFF, 32'd0);
        send_request(0, 25'h1FF_FFFE, 4'd0, 32'h0);
        send_request(0, 25'h100_0000, 4'd1, 32'h0);
        send_request(1, 25'd0, 4'd0, 32'hAAAA_5555);
        send_request(0, 25'h155_5555, 4'd5, 32'h5555_AAAA);
    endtask

    task automatic test_full_table();
        setup_pool(32'h1000, 32'd4096, 32'd0);
        for (int i = 0; i < 70; i++)
            send_request(0, 25'($urandom_range(1, 40)), 4'($urandom_range(0, 2)), 32'h0);
        for (int i = 0; i < 30; i++)
            send_request(1, 25'd0, 4'd0, pick_free_addr());
    endtask

    task automatic test_backpressure();
        setup_pool(32'h0, 32'd65536, 32'd32);
        fork
            long_hold(400);
        join_none
        for (int i = 0; i < 12; i++)
            send_request(i % 3 == 2, 25'($urandom_range(1, 500)), 4'd2, pick_free_addr());
    endtask

    task automatic test_random(int n);
        for (int p = 0; p < 4; p++) begin
            setup_pool($urandom, 32'($urandom_range(1, 65536)),
                       32'($urandom_range(0, 4096)));
            for (int i = 0; i < n / 4; i++) begin
                if ($urandom_range(0, 9) < 6)
                    send_request(0, 25'($urandom_range(0, 2000)),
                                 4'($urandom_range(0, 15)), $urandom);
                else if ($urandom_range(0, 9) == 0)
                    send_request(0, 25'($urandom), 4'($urandom), $urandom);
                else
                    send_request(1, 25'($urandom), 4'($urandom), pick_free_addr());
            end
        end
        // last part with no idling
        stall_en = 0;
        setup_pool(32'h0, 32'd8192, 32'd16);
        for (int i = 0; i < 100; i++)
            send_request($urandom_range(0, 2) == 0, 25'($urandom_range(0, 600)),
                         4'($urandom_range(0, 6)), pick_free_addr());
    endtask

    initial begin
        cycles = 0;
        errors = 0;
        sent_count = 0;
        got_count = 0;
        stall_en = 1;
        hold_off = 0;
        rst_n = 0;
        req.valid = 0;
        req.action = 0;
        req.request_size = 0;
        req.align_log2 = 0;
        req.free_address = 0;
        cfg.valid = 0;
        cfg.index = REG_NONE;
        cfg.data = 0;
        m_base = 0;
        m_size = POOL_SIZE_RST;
        m_margin = MARGIN_RST;
        m_total = 0;
        rebuild_table();
        repeat (4) @(posedge clk);
        rst_n <= 1;
        repeat (3) @(posedge clk);
        test_directed();
        test_full_table();
        test_backpressure();
        test_random(800);
        drain();
        $display("requests sent %0d, results checked %0d, over several pool settings",
                 sent_count, got_count);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
